/* rtl/core/lz77_type10_decompressor_unit_assert.svh */
// Assertion macros shared by the LZ77 type 0x10 decompressor RTL.
`ifndef LZ77_TYPE10_DECOMPRESSOR_UNIT_ASSERT_SVH
`define LZ77_TYPE10_DECOMPRESSOR_UNIT_ASSERT_SVH

// Checks that a condition implies another one in the same cycle.
`define LZD_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Checks that a condition implies another one in the following cycle.
`define LZD_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/core/lz77d_pkg.sv */
// Package with widths, codes and types of the LZ77 type 0x10 decompressor.
`timescale 1ns / 1ps
`default_nettype none

package lz77d_pkg;

    // Field widths.
    localparam int LZ_BYTE_W   = 8;
    localparam int LZ_LEN_W    = 24;
    localparam int LZ_SIZE_W   = 25;
    localparam int LZ_STATUS_W = 2;
    localparam int LZ_COUNT_W  = 5;
    localparam int LZ_DIST_W   = 13;

    // Default history depth in bytes.
    localparam int LZ_HISTORY_DEPTH = 4096;

    // Stream constants.
    localparam logic [LZ_BYTE_W-1:0]  LZ_HEADER_TYPE = 8'h10;
    localparam logic [LZ_COUNT_W-1:0] LZ_COUNT_BIAS  = 5'd3;
    localparam logic [LZ_SIZE_W-1:0]  LZ_SIZE_MAX    = 25'h1FF_FFFF;

    typedef logic [LZ_STATUS_W-1:0] t_status;

    // Result status codes.
    localparam t_status ST_DATA       = 2'd0;
    localparam t_status ST_BAD_HEADER = 2'd1;
    localparam t_status ST_BAD_DIST   = 2'd2;
    localparam t_status ST_EMPTY      = 2'd3;

endpackage

`default_nettype wire

/* rtl/core/lz77d_stream_if.sv */
// Valid/ready channel interfaces for compressed input and decompressed output.
`timescale 1ns / 1ps
`default_nettype none

// Compressed byte channel.
interface lz77d_in_if import lz77d_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [LZ_BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// Result channel.
interface lz77d_out_if import lz77d_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [LZ_BYTE_W-1:0] out_byte;
    t_status              status;
    logic                 last;
    logic [LZ_SIZE_W-1:0] compressed_size;

    modport source (output valid, output out_byte, output status, output last,
                    output compressed_size, input ready);
    modport sink   (input valid, input out_byte, input status, input last,
                    input compressed_size, output ready);
endinterface

`default_nettype wire

/* rtl/core/lz77_type10_decompressor_unit.sv */
// LZ77 type 0x10 stream decompressor built around a one-port-write history RAM.
//
// Usage: compressed bytes enter on i_in, one per beat, starting with the 0x10 type
// byte and a 24-bit little-endian length. Results leave on o_out, one per beat:
// a data byte, or an error/empty-stream code, with last set on the final beat of
// a stream and compressed_size giving the input bytes consumed for that stream.
// Results: a 0x10 type byte, a length byte of a non-empty stream and a flag byte
// give no result. A literal byte appears on o_out in the cycle after its beat. A
// back-reference issues one history read and shows one byte per cycle while o_out
// is not stalled; the phase, history read and output registers lie between the
// second reference beat and its first byte. The read-then-write path of the
// history RAM sets this rate, with the byte just written forwarded at distance one.
// Throughput: one input byte per cycle for header, flag and literal bytes while o_out is not stalled.
// Reset: the decoder waits for a type byte; the history RAM is not cleared, since
// the distance check never lets a copy read beyond the bytes of the current stream.
// Stalls: the output register holds while o_out.ready is low; i_in.ready drops
// and the copy engine pauses until the pending beat is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "lz77_type10_decompressor_unit_assert.svh"

module lz77_type10_decompressor_unit
    import lz77d_pkg::*;
#(
    parameter int HISTORY_DEPTH = LZ_HISTORY_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    lz77d_in_if.sink    i_in,
    lz77d_out_if.source o_out
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    // Decoder phases.
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_LEN0   = 3'd1;
    localparam logic [2:0] PH_LEN1   = 3'd2;
    localparam logic [2:0] PH_LEN2   = 3'd3;
    localparam logic [2:0] PH_FLAG   = 3'd4;
    localparam logic [2:0] PH_TOKEN  = 3'd5;
    localparam logic [2:0] PH_REF2   = 3'd6;
    localparam logic [2:0] PH_COPY   = 3'd7;

    // Control state.
    logic [2:0]            r_phase,     n_phase;
    logic [LZ_BYTE_W-1:0]  r_flag_bits, n_flag_bits;
    logic [2:0]            r_flag_idx,  n_flag_idx;
    logic [LZ_LEN_W-1:0]   r_total_len, n_total_len;
    logic [LZ_LEN_W-1:0]   r_produced,  n_produced;
    logic [LZ_SIZE_W-1:0]  r_consumed,  n_consumed;
    logic [LZ_COUNT_W-1:0] r_cp_left,   n_cp_left;
    logic                  r_rd_pend,   n_rd_pend;
    logic                  r_out_valid, n_out_valid;

    // Payload state.
    logic [LZ_BYTE_W-1:0]  r_ref_first, n_ref_first;
    logic [AW-1:0]         r_cp_src,    n_cp_src;
    logic [LZ_BYTE_W-1:0]  r_out_byte,  n_out_byte;
    t_status               r_out_status, n_out_status;
    logic                  r_out_last,  n_out_last;
    logic [LZ_SIZE_W-1:0]  r_out_size,  n_out_size;

    // History memory and its read side.
    logic [LZ_BYTE_W-1:0]  r_hist [HISTORY_DEPTH];
    logic [LZ_BYTE_W-1:0]  r_hist_q;
    logic                  r_fwd;
    logic [LZ_BYTE_W-1:0]  r_fwd_data;

    logic                  can_emit;
    logic                  in_acc;
    logic [LZ_BYTE_W-1:0]  in_b;
    logic [LZ_SIZE_W-1:0]  in_consumed;
    logic [LZ_DIST_W-1:0]  ref_dist;
    logic [LZ_COUNT_W-1:0] ref_count;
    logic                  dist_bad;
    logic [LZ_LEN_W-1:0]   produced_inc;
    logic                  len_done;
    logic [LZ_BYTE_W-1:0]  cp_data;
    logic                  cp_emit;
    logic                  cp_issue;
    logic                  lit_emit;
    logic                  hist_we;
    logic [AW-1:0]         hist_wa;
    logic [LZ_BYTE_W-1:0]  hist_wd;
    logic [LZ_LEN_W-1:0]   len_full;
    logic [2:0]            nt_phase;
    logic [2:0]            nt_idx;
    logic [LZ_BYTE_W-1:0]  nt_bits;

    // Handshake: the output register is free this cycle if empty or draining.
    assign can_emit   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_phase != PH_COPY) && can_emit;
    assign in_acc     = i_in.valid && i_in.ready;
    assign in_b       = i_in.in_byte;

    // Consumed count after this beat, saturating.
    assign in_consumed = (r_phase == PH_HEADER) ? {{(LZ_SIZE_W-1){1'b0}}, 1'b1}
                       : (r_consumed == LZ_SIZE_MAX) ? r_consumed
                       : r_consumed + 1'b1;

    // Back-reference decode and distance check.
    assign ref_dist  = {1'b0, r_ref_first[3:0], in_b} + 1'b1;
    assign ref_count = {1'b0, r_ref_first[7:4]} + LZ_COUNT_BIAS;
    assign dist_bad  = ({{(LZ_LEN_W-LZ_DIST_W){1'b0}}, ref_dist} > r_total_len) ||
                       ({{(LZ_LEN_W-LZ_DIST_W){1'b0}}, ref_dist} > r_produced);

    assign produced_inc = r_produced + 1'b1;
    assign len_done     = produced_inc >= r_total_len;
    assign len_full     = {in_b, r_total_len[15:0]};

    // Copy engine: one read issued and one byte written per cycle while the output register is free.
    assign cp_data  = r_fwd ? r_fwd_data : r_hist_q;
    assign cp_emit  = (r_phase == PH_COPY) && r_rd_pend && can_emit;
    assign cp_issue = (r_phase == PH_COPY) && (r_cp_left != '0) && (!r_rd_pend || cp_emit);
    assign lit_emit = in_acc && (r_phase == PH_TOKEN) && !r_flag_bits[7];

    assign hist_we = lit_emit || cp_emit;
    assign hist_wa = r_produced[AW-1:0];
    assign hist_wd = lit_emit ? in_b : cp_data;

    // Advance to the next token slot of the current flag byte.
    assign nt_bits  = {r_flag_bits[LZ_BYTE_W-2:0], 1'b0};
    assign nt_idx   = (r_flag_idx == 3'd7) ? 3'd0 : r_flag_idx + 1'b1;
    assign nt_phase = (r_flag_idx == 3'd7) ? PH_FLAG : PH_TOKEN;

    // History RAM with registered read data.
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist[hist_wa] <= hist_wd;
        end
        if (cp_issue) begin
            r_hist_q <= r_hist[r_cp_src];
        end
    end

    // Forward a byte written in the same cycle as the read of its address.
    always_ff @(posedge i_clk) begin
        if (cp_issue) begin
            r_fwd      <= cp_emit && (r_cp_src == hist_wa);
            r_fwd_data <= cp_data;
        end
    end

    // Next-state logic of the decoder and copy engine.
    always_comb begin
        n_phase      = r_phase;
        n_flag_bits  = r_flag_bits;
        n_flag_idx   = r_flag_idx;
        n_total_len  = r_total_len;
        n_produced   = r_produced;
        n_consumed   = in_acc ? in_consumed : r_consumed;
        n_cp_left    = cp_issue ? r_cp_left - 1'b1 : r_cp_left;
        n_cp_src     = cp_issue ? r_cp_src + 1'b1 : r_cp_src;
        n_rd_pend    = cp_issue ? 1'b1 : (cp_emit ? 1'b0 : r_rd_pend);
        n_ref_first  = r_ref_first;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_byte   = r_out_byte;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        n_out_size   = r_out_size;

        case (r_phase)
            PH_HEADER: begin
                if (in_acc) begin
                    n_total_len = '0;
                    n_produced  = '0;
                    n_flag_bits = '0;
                    n_flag_idx  = '0;
                    if (in_b != LZ_HEADER_TYPE) begin
                        n_out_valid  = 1'b1;
                        n_out_byte   = '0;
                        n_out_status = ST_BAD_HEADER;
                        n_out_last   = 1'b1;
                        n_out_size   = in_consumed;
                    end else begin
                        n_phase = PH_LEN0;
                    end
                end
            end
            PH_LEN0: begin
                if (in_acc) begin
                    n_total_len = {{(LZ_LEN_W-LZ_BYTE_W){1'b0}}, in_b};
                    n_phase     = PH_LEN1;
                end
            end
            PH_LEN1: begin
                if (in_acc) begin
                    n_total_len = {{LZ_BYTE_W{1'b0}}, in_b, r_total_len[7:0]};
                    n_phase     = PH_LEN2;
                end
            end
            PH_LEN2: begin
                if (in_acc) begin
                    n_total_len = len_full;
                    if (len_full == '0) begin
                        n_phase      = PH_HEADER;
                        n_out_valid  = 1'b1;
                        n_out_byte   = '0;
                        n_out_status = ST_EMPTY;
                        n_out_last   = 1'b1;
                        n_out_size   = in_consumed;
                    end else begin
                        n_phase = PH_FLAG;
                    end
                end
            end
            PH_FLAG: begin
                if (in_acc) begin
                    n_flag_bits = in_b;
                    n_flag_idx  = '0;
                    n_phase     = PH_TOKEN;
                end
            end
            PH_TOKEN: begin
                if (in_acc) begin
                    if (r_flag_bits[7]) begin
                        n_ref_first = in_b;
                        n_phase     = PH_REF2;
                    end else begin
                        n_produced   = produced_inc;
                        n_out_valid  = 1'b1;
                        n_out_byte   = in_b;
                        n_out_status = ST_DATA;
                        n_out_last   = len_done;
                        n_out_size   = len_done ? in_consumed : '0;
                        if (len_done) begin
                            n_phase = PH_HEADER;
                        end else begin
                            n_phase     = nt_phase;
                            n_flag_idx  = nt_idx;
                            n_flag_bits = nt_bits;
                        end
                    end
                end
            end
            PH_REF2: begin
                if (in_acc) begin
                    if (dist_bad) begin
                        n_phase      = PH_HEADER;
                        n_out_valid  = 1'b1;
                        n_out_byte   = '0;
                        n_out_status = ST_BAD_DIST;
                        n_out_last   = 1'b1;
                        n_out_size   = in_consumed;
                    end else begin
                        n_cp_left = ref_count;
                        n_cp_src  = r_produced[AW-1:0] - ref_dist[AW-1:0];
                        n_phase   = PH_COPY;
                    end
                end
            end
            PH_COPY: begin
                if (cp_emit) begin
                    n_produced   = produced_inc;
                    n_out_valid  = 1'b1;
                    n_out_byte   = cp_data;
                    n_out_status = ST_DATA;
                    n_out_last   = len_done;
                    n_out_size   = len_done ? r_consumed : '0;
                    if (len_done) begin
                        n_phase   = PH_HEADER;
                        n_rd_pend = 1'b0;
                    end else if (r_cp_left == '0) begin
                        n_phase     = nt_phase;
                        n_flag_idx  = nt_idx;
                        n_flag_bits = nt_bits;
                    end
                end
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_flag_bits <= '0;
            r_flag_idx  <= '0;
            r_total_len <= '0;
            r_produced  <= '0;
            r_consumed  <= '0;
            r_cp_left   <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_flag_bits <= n_flag_bits;
            r_flag_idx  <= n_flag_idx;
            r_total_len <= n_total_len;
            r_produced  <= n_produced;
            r_consumed  <= n_consumed;
            r_cp_left   <= n_cp_left;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ref_first  <= n_ref_first;
        r_cp_src     <= n_cp_src;
        r_out_byte   <= n_out_byte;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
        r_out_size   <= n_out_size;
    end

    // Output channel.
    assign o_out.valid           = r_out_valid;
    assign o_out.out_byte        = r_out_byte;
    assign o_out.status          = r_out_status;
    assign o_out.last            = r_out_last;
    assign o_out.compressed_size = r_out_size;

    // The output never runs past the stated length within a stream.
    `LZD_ASSERT_SAME(a_produced_in_len, r_phase != PH_HEADER, r_produced <= r_total_len, "produced count passed the stream length")

    // A history read is only outstanding while a copy runs.
    `LZD_ASSERT_SAME(a_read_in_copy, r_rd_pend, r_phase == PH_COPY, "history read pending outside a copy")

    // A running copy always has a byte left to read or to write.
    `LZD_ASSERT_SAME(a_copy_alive, r_phase == PH_COPY, (r_cp_left != '0) || r_rd_pend, "copy phase with no work left")

    // A final data beat is shown only once the full length has been produced.
    `LZD_ASSERT_SAME(a_last_at_len, r_out_valid && r_out_last && (r_out_status == ST_DATA), r_produced == r_total_len, "last data beat before the stream length")

    // A reference with a valid distance starts the copy engine.
    `LZD_ASSERT_NEXT(a_copy_start, in_acc && (r_phase == PH_REF2) && !dist_bad, r_phase == PH_COPY, "valid reference did not start a copy")

endmodule

`default_nettype wire

/* bench/lz77_type10_decompressor_unit_tb.sv */
// Self-checking testbench for the LZ77 type 0x10 stream decompressor.
`timescale 1ns / 1ps

module lz77_type10_decompressor_unit_tb;
    import lz77d_pkg::*;

    // Decoder phases of the local stream model.
    typedef enum logic [2:0] {
        DEC_TYPE,
        DEC_LEN_LO,
        DEC_LEN_MID,
        DEC_LEN_HI,
        DEC_FLAGS,
        DEC_TOKEN,
        DEC_REF_LO
    } t_dec_phase;

    // One decoded beat as it should leave the block.
    typedef struct packed {
        logic [LZ_BYTE_W-1:0] data;
        t_status              status;
        logic                 last;
        logic [LZ_SIZE_W-1:0] size;
    } t_out_beat;

    logic i_clk;
    logic i_rst_n;

    lz77d_in_if  in_if ();
    lz77d_out_if out_if ();

    lz77_type10_decompressor_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Compressed bytes waiting to be sent, and decoded beats still owed by the block.
    logic [LZ_BYTE_W-1:0] stream_bytes [$];
    t_out_beat            decoded_q [$];

    // State of the local decoder.
    t_dec_phase           dec_phase = DEC_TYPE;
    logic [LZ_BYTE_W-1:0] history [0:LZ_HISTORY_DEPTH-1];
    logic [LZ_BYTE_W-1:0] flag_bits = '0;
    logic [2:0]           flag_idx = '0;
    logic [LZ_LEN_W-1:0]  total_len = '0;
    logic [LZ_LEN_W-1:0]  produced = '0;
    logic [LZ_BYTE_W-1:0] ref_hi = '0;
    logic [LZ_SIZE_W-1:0] consumed = '0;

    int  mismatches = 0;
    int  beats_checked = 0;
    int  bytes_fed = 0;
    int  items_queued = 0;
    int  streams_built = 0;
    bit  idle_off = 1'b0;
    int  in_gap = 0;
    int  out_gap = 0;

    // Directed opening: two bad headers, an empty stream, a stream with an
    // 18-byte overlapping copy and a truncated copy, then a maximum length
    // stream whose reference at distance 4096 fails the distance check.
    logic [LZ_BYTE_W-1:0] directed [24] = '{
        8'hFF, 8'h00,
        8'h10, 8'h00, 8'h00, 8'h00,
        8'h10, 8'h14, 8'h00, 8'h00, 8'h60, 8'hAA, 8'hF0, 8'h00, 8'h00, 8'h01,
        8'h10, 8'hFF, 8'hFF, 8'hFF, 8'h40, 8'h55, 8'hFF, 8'hFF
    };

    // Clock with a 2 ns period.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic void post_result(input logic [LZ_BYTE_W-1:0] data,
                                        input t_status status, input logic last);
        t_out_beat beat;
        beat.data   = data;
        beat.status = status;
        beat.last   = last;
        beat.size   = last ? consumed : '0;
        decoded_q.push_back(beat);
    endfunction

    // Appends one byte to the output and the history; returns 1 when the stream is complete.
    function automatic bit append_byte(input logic [LZ_BYTE_W-1:0] b);
        bit done;
        history[produced[11:0]] = b;
        produced = produced + 1'b1;
        done = (produced >= total_len);
        post_result(b, ST_DATA, done);
        if (done) begin
            dec_phase = DEC_TYPE;
        end
        return done;
    endfunction

    function automatic void advance_token();
        flag_bits = flag_bits << 1;
        if (flag_idx == 3'd7) begin
            flag_idx  = '0;
            dec_phase = DEC_FLAGS;
        end else begin
            flag_idx  = flag_idx + 1'b1;
            dec_phase = DEC_TOKEN;
        end
    endfunction

    // Works out the decoded beats that one accepted compressed byte causes.
    function automatic void decode_byte(input logic [LZ_BYTE_W-1:0] b);
        logic [LZ_COUNT_W-1:0] count;
        logic [LZ_DIST_W-1:0]  back_dist;
        logic [11:0]           src;
        bit                    done;
        int                    j;
        if (dec_phase == DEC_TYPE) begin
            consumed  = LZ_SIZE_W'(1);
            total_len = '0;
            produced  = '0;
            flag_bits = '0;
            flag_idx  = '0;
            if (b != LZ_HEADER_TYPE) begin
                post_result('0, ST_BAD_HEADER, 1'b1);
            end else begin
                dec_phase = DEC_LEN_LO;
            end
            return;
        end
        if (consumed < LZ_SIZE_MAX) begin
            consumed = consumed + 1'b1;
        end
        case (dec_phase)
            DEC_LEN_LO: begin
                total_len[7:0] = b;
                dec_phase = DEC_LEN_MID;
            end
            DEC_LEN_MID: begin
                total_len[15:8] = b;
                dec_phase = DEC_LEN_HI;
            end
            DEC_LEN_HI: begin
                total_len[23:16] = b;
                if (total_len == '0) begin
                    dec_phase = DEC_TYPE;
                    post_result('0, ST_EMPTY, 1'b1);
                end else begin
                    dec_phase = DEC_FLAGS;
                end
            end
            DEC_FLAGS: begin
                flag_bits = b;
                flag_idx  = '0;
                dec_phase = DEC_TOKEN;
            end
            DEC_TOKEN: begin
                if (flag_bits[7]) begin
                    ref_hi    = b;
                    dec_phase = DEC_REF_LO;
                end else if (!append_byte(b)) begin
                    advance_token();
                end
            end
            DEC_REF_LO: begin
                count     = ref_hi[7:4] + LZ_COUNT_BIAS;
                back_dist = {1'b0, ref_hi[3:0], b} + 1'b1;
                if (back_dist > total_len || back_dist > produced) begin
                    dec_phase = DEC_TYPE;
                    post_result('0, ST_BAD_DIST, 1'b1);
                end else begin
                    done = 1'b0;
                    for (j = 0; j < count && !done; j++) begin
                        src  = produced[11:0] - back_dist[11:0];
                        done = append_byte(history[src]);
                    end
                    if (!done) begin
                        advance_token();
                    end
                end
            end
            default: dec_phase = DEC_TYPE;
        endcase
    endfunction

    function automatic void queue_byte(input logic [LZ_BYTE_W-1:0] b);
        stream_bytes.push_back(b);
        items_queued++;
    endfunction

    // Builds one compressed stream with random literals and references. A broken
    // stream may end on a reference that reaches past the bytes produced so far.
    function automatic void add_stream(input bit broken);
        int                   len;
        int                   made;
        int                   cnt;
        int                   back_dist;
        int                   lim;
        int                   i;
        bit                   stop;
        logic [3:0]           cnt_code;
        logic [11:0]          dist_code;
        logic [LZ_BYTE_W-1:0] flag;
        logic [LZ_BYTE_W-1:0] toks [$];
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 80) : $urandom_range(1, 40);
        streams_built++;
        queue_byte(LZ_HEADER_TYPE);
        queue_byte(len[7:0]);
        queue_byte(len[15:8]);
        queue_byte(len[23:16]);
        made = 0;
        stop = 1'b0;
        while (made < len && !stop) begin
            flag = 8'($urandom_range(0, 255));
            toks.delete();
            for (i = 7; i >= 0 && made < len && !stop; i--) begin
                if (made == 0) begin
                    flag[i] = 1'b0;
                end
                if (flag[i]) begin
                    cnt = $urandom_range(3, 18);
                    if (broken && $urandom_range(0, 2) == 0) begin
                        back_dist = made + $urandom_range(1, 40);
                        stop = 1'b1;
                    end else begin
                        lim  = (made > LZ_HISTORY_DEPTH) ? LZ_HISTORY_DEPTH : made;
                        back_dist = $urandom_range(0, 1) ? $urandom_range(1, (lim < 4) ? lim : 4)
                                                         : $urandom_range(1, lim);
                    end
                    if (back_dist > LZ_HISTORY_DEPTH) begin
                        back_dist = LZ_HISTORY_DEPTH;
                    end
                    cnt_code  = 4'(cnt - 3);
                    dist_code = 12'(back_dist - 1);
                    toks.push_back({cnt_code, dist_code[11:8]});
                    toks.push_back(dist_code[7:0]);
                    made += cnt;
                end else begin
                    toks.push_back(8'($urandom_range(0, 255)));
                    made++;
                end
            end
            queue_byte(flag);
            foreach (toks[k]) begin
                queue_byte(toks[k]);
            end
        end
    endfunction

    task automatic wait_drained();
        while (stream_bytes.size() != 0 || in_if.valid || decoded_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Driver: sends queued bytes, with random idle bursts, and predicts each accepted beat.
    always @(posedge i_clk) begin : drive_in
        logic                 nxt_valid;
        logic [LZ_BYTE_W-1:0] nxt_byte;
        if (!i_rst_n) begin
            in_if.valid   <= 1'b0;
            in_if.in_byte <= '0;
            in_gap = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                decode_byte(in_if.in_byte);
                bytes_fed++;
            end
            if (!in_if.valid || in_if.ready) begin
                nxt_valid = 1'b0;
                nxt_byte  = in_if.in_byte;
                if (in_gap > 0) begin
                    in_gap--;
                end else if (!idle_off && $urandom_range(0, 7) == 0) begin
                    in_gap = $urandom_range(0, 10);
                end else if (stream_bytes.size() > 0) begin
                    nxt_valid = 1'b1;
                    nxt_byte  = stream_bytes.pop_front();
                end
                in_if.valid   <= nxt_valid;
                in_if.in_byte <= nxt_byte;
            end
        end
    end

    // Monitor: stalls the result channel in random bursts and checks every beat taken.
    always @(posedge i_clk) begin : watch_out
        t_out_beat want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            out_gap = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                beats_checked++;
                if (decoded_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected beat, expected none, got byte %02h status %0d last %0d",
                             $time, out_if.out_byte, out_if.status, out_if.last);
                end else begin
                    want = decoded_q.pop_front();
                    if (out_if.out_byte !== want.data) begin
                        mismatches++;
                        $display("%0t: out_byte expected %02h, got %02h",
                                 $time, want.data, out_if.out_byte);
                    end
                    if (out_if.status !== want.status) begin
                        mismatches++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, out_if.status);
                    end
                    if (out_if.last !== want.last) begin
                        mismatches++;
                        $display("%0t: last expected %0d, got %0d",
                                 $time, want.last, out_if.last);
                    end
                    if (out_if.compressed_size !== want.size) begin
                        mismatches++;
                        $display("%0t: compressed_size expected %0d, got %0d",
                                 $time, want.size, out_if.compressed_size);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_if.ready <= 1'b0;
            end else if (!idle_off && $urandom_range(0, 7) == 0) begin
                out_gap = $urandom_range(0, 10);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Stimulus sequence and end of run.
    initial begin : run_streams
        int r;
        bit paused;
        in_if.valid   = 1'b0;
        in_if.in_byte = '0;
        out_if.ready  = 1'b0;
        i_rst_n       = 1'b0;
        paused        = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            queue_byte(directed[k]);
        end
        streams_built += 5;
        wait_drained();

        // Random part: mostly well-formed streams, some broken ones and stray bytes.
        while (items_queued < 80) begin
            while (stream_bytes.size() > 8) begin
                @(posedge i_clk);
            end
            idle_off = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 9);
            if (r == 0) begin
                r = $urandom_range(0, 254);
                queue_byte(8'((r >= LZ_HEADER_TYPE) ? r + 1 : r));
            end else begin
                add_stream(r <= 2);
            end
            if (!paused && items_queued > 50) begin
                wait_drained();
                paused = 1'b1;
            end
        end

        // Closing streams with both channels running flat out.
        while (stream_bytes.size() > 0) begin
            @(posedge i_clk);
        end
        idle_off = 1'b1;
        repeat (2) add_stream(1'b0);

        wait_drained();
        repeat (40) @(posedge i_clk);

        $display("Decoded %0d streams from %0d compressed bytes under random stalls.",
                 streams_built, bytes_fed);
        $display("Checked %0d result beats, with %0d mismatching fields.",
                 beats_checked, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/lz77d_pkg.sv
rtl/core/lz77d_stream_if.sv
rtl/core/lz77_type10_decompressor_unit.sv
bench/lz77_type10_decompressor_unit_tb.sv
